/* rtl/qfab_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfab_pkg - shared types and constants for the quad fill alpha blender
// Word formats, configuration register map, fill colours and pipeline sizes.
// ----------------------------------------------------------------------------
package qfab_pkg;

  // geometry
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;
  localparam int NUM_VTX    = 4;
  localparam int LANE_STEP  = 16;
  localparam int VTX_BITS   = COORD_BITS + FRAC_BITS;
  localparam int LANE_W     = (VTX_BITS >= LANE_STEP) ? LANE_STEP : VTX_BITS;
  localparam int PIX_W      = 12;
  localparam int PX_W       = PIX_W + FRAC_BITS;
  localparam int DIFF_W     = ((PX_W > LANE_W) ? PX_W : LANE_W) + 1;
  localparam int PROD_W     = 2 * DIFF_W;

  // pipeline
  localparam int NUM_STAGES = 4;

  // blend arithmetic
  localparam int ALPHA_W = 8;
  localparam int MIX_W   = 14;

  typedef enum logic [2:0] {
    REG_QUAD_X    = 3'd0,
    REG_QUAD_Y    = 3'd1,
    REG_ENABLED   = 3'd2,
    REG_OCCUPIED  = 3'd3,
    REG_ALPHA     = 3'd4,
    REG_WIDTH     = 3'd5,
    REG_HEIGHT    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] dst_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] out_pixel;
    logic        covered;
  } pix_out_t;

  typedef struct packed {
    logic [63:0]        quad_x_coords;
    logic [63:0]        quad_y_coords;
    logic               cell_enabled;
    logic               cell_occupied;
    logic [ALPHA_W-1:0] fill_alpha;
    logic [11:0]        image_width;
    logic [11:0]        image_height;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  localparam logic [15:0] FILL_FREE = pack565(8'd46, 8'd204, 8'd113);
  localparam logic [15:0] FILL_OCC  = pack565(8'd255, 8'd91, 8'd91);
  localparam logic [15:0] FILL_DIS  = pack565(8'd140, 8'd140, 8'd140);

endpackage

/* rtl/qfab_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfab_cfg - configuration register file
// Seven registers written through a valid/ready port that is always ready.
// ----------------------------------------------------------------------------
module qfab_cfg import qfab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quad_x_coords <= '0;
      cfg.quad_y_coords <= '0;
      cfg.cell_enabled  <= 1'b1;
      cfg.cell_occupied <= 1'b0;
      cfg.fill_alpha    <= ALPHA_W'(70);
      cfg.image_width   <= 12'd800;
      cfg.image_height  <= 12'd600;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_QUAD_X:   cfg.quad_x_coords <= cfg_data;
        REG_QUAD_Y:   cfg.quad_y_coords <= cfg_data;
        REG_ENABLED:  cfg.cell_enabled  <= cfg_data[0];
        REG_OCCUPIED: cfg.cell_occupied <= cfg_data[0];
        REG_ALPHA:    cfg.fill_alpha    <= cfg_data[ALPHA_W-1:0];
        REG_WIDTH:    cfg.image_width   <= cfg_data[11:0];
        REG_HEIGHT:   cfg.image_height  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/qfab_pipe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfab_pipe_ctrl - stage valid bits and load enables
// A stage loads when it is empty or the stage after it moves on.
// ----------------------------------------------------------------------------
module qfab_pipe_ctrl import qfab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_stall,
  output logic       in_stall,
  output logic       out_valid,
  output pipe_ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] valid;

  always_comb begin
    ctrl.load[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ctrl.load[k] = !valid[k] || ctrl.load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctrl.load[0]) valid[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ctrl.load[k]) valid[k] <= valid[k-1];
      end
    end
  end

  assign in_stall  = !ctrl.load[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule

/* rtl/qfab_inside.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfab_inside - image bounds and even-odd quad test
// Stage 1 edge differences, stage 2 cross products, stage 3 parity.
// ----------------------------------------------------------------------------
module qfab_inside import qfab_pkg::*; (
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  cfg_t       cfg,
  input  pix_in_t    pix,
  output logic       covered
);

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // stage 1
  logic [NUM_VTX-1:0] s1_straddle, s1_rising;
  diff_t              s1_dxp [NUM_VTX];
  diff_t              s1_dye [NUM_VTX];
  diff_t              s1_dxe [NUM_VTX];
  diff_t              s1_dyp [NUM_VTX];
  logic               s1_in_img;

  // stage 2
  logic [NUM_VTX-1:0] s2_straddle, s2_rising;
  prod_t              s2_lhs [NUM_VTX];
  prod_t              s2_rhs [NUM_VTX];
  logic               s2_in_img;

  logic [NUM_VTX-1:0] straddle_next, rising_next, toggle;
  diff_t              dxp_next [NUM_VTX];
  diff_t              dye_next [NUM_VTX];
  diff_t              dxe_next [NUM_VTX];
  diff_t              dyp_next [NUM_VTX];
  diff_t              px, py;

  always_comb begin
    diff_t xa, ya, xb, yb;
    px = diff_t'(DIFF_W'(pix.pixel_x) << FRAC_BITS);
    py = diff_t'(DIFF_W'(pix.pixel_y) << FRAC_BITS);
    for (int e = 0; e < NUM_VTX; e++) begin
      xa = diff_t'(DIFF_W'(cfg.quad_x_coords[LANE_STEP*e +: LANE_W]));
      ya = diff_t'(DIFF_W'(cfg.quad_y_coords[LANE_STEP*e +: LANE_W]));
      xb = diff_t'(DIFF_W'(cfg.quad_x_coords[LANE_STEP*((e+NUM_VTX-1)%NUM_VTX) +: LANE_W]));
      yb = diff_t'(DIFF_W'(cfg.quad_y_coords[LANE_STEP*((e+NUM_VTX-1)%NUM_VTX) +: LANE_W]));
      straddle_next[e] = (ya > py) != (yb > py);
      rising_next[e]   = yb > ya;
      dxp_next[e]      = px - xa;
      dye_next[e]      = yb - ya;
      dxe_next[e]      = xb - xa;
      dyp_next[e]      = py - ya;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_straddle <= straddle_next;
      s1_rising   <= rising_next;
      s1_dxp      <= dxp_next;
      s1_dye      <= dye_next;
      s1_dxe      <= dxe_next;
      s1_dyp      <= dyp_next;
      s1_in_img   <= (pix.pixel_x < cfg.image_width) && (pix.pixel_y < cfg.image_height);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_straddle <= s1_straddle;
      s2_rising   <= s1_rising;
      s2_in_img   <= s1_in_img;
      for (int e = 0; e < NUM_VTX; e++) begin
        s2_lhs[e] <= prod_t'(s1_dxp[e]) * prod_t'(s1_dye[e]);
        s2_rhs[e] <= prod_t'(s1_dxe[e]) * prod_t'(s1_dyp[e]);
      end
    end
  end

  // crossing test on the products, direction set by which end is higher
  always_comb begin
    for (int e = 0; e < NUM_VTX; e++) begin
      toggle[e] = s2_straddle[e] &&
                  (s2_rising[e] ? (s2_lhs[e] < s2_rhs[e]) : (s2_lhs[e] > s2_rhs[e]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) covered <= s2_in_img && (^toggle);
  end

endmodule

/* rtl/qfab_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfab_blend - per-channel alpha blend of the fill colour
// Stage 2 products, stage 3 sums, stage 4 divide by 255 and output select.
// ----------------------------------------------------------------------------
module qfab_blend import qfab_pkg::*; (
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  cfg_t       cfg,
  input  logic [15:0] dst_pixel,
  input  logic       covered,
  output pix_out_t   result
);

  typedef logic [MIX_W-1:0] mix_t;

  // exact floor(t/255) for t below 16320
  function automatic logic [5:0] div255(input mix_t t);
    logic [MIX_W:0] s;
    s = (MIX_W+1)'(t) + (MIX_W+1)'(t >> 8) + (MIX_W+1)'(1);
    return s[13:8];
  endfunction

  logic [15:0]        s1_dst, s2_dst, s3_dst;
  mix_t               s2_ps [3];
  mix_t               s2_pd [3];
  mix_t               s3_sum [3];
  logic [15:0]        fill;
  logic [ALPHA_W-1:0] alpha_inv;
  logic [5:0]         src_ch [3];
  logic [5:0]         dst_ch [3];
  logic [15:0]        blended;

  always_comb begin
    priority if (!cfg.cell_enabled) fill = FILL_DIS;
    else if (cfg.cell_occupied)     fill = FILL_OCC;
    else                            fill = FILL_FREE;
    alpha_inv = ALPHA_W'(255) - cfg.fill_alpha;
    src_ch[0] = {1'b0, fill[15:11]};
    src_ch[1] = fill[10:5];
    src_ch[2] = {1'b0, fill[4:0]};
    dst_ch[0] = {1'b0, s1_dst[15:11]};
    dst_ch[1] = s1_dst[10:5];
    dst_ch[2] = {1'b0, s1_dst[4:0]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) s1_dst <= dst_pixel;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_dst <= s1_dst;
      for (int c = 0; c < 3; c++) begin
        s2_ps[c] <= mix_t'(src_ch[c]) * mix_t'(cfg.fill_alpha);
        s2_pd[c] <= mix_t'(dst_ch[c]) * mix_t'(alpha_inv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_dst <= s2_dst;
      for (int c = 0; c < 3; c++) begin
        s3_sum[c] <= s2_ps[c] + s2_pd[c];
      end
    end
  end

  always_comb begin
    logic [5:0] r, g, b;
    r = div255(s3_sum[0]);
    g = div255(s3_sum[1]);
    b = div255(s3_sum[2]);
    blended = {r[4:0], g, b[4:0]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      result.out_pixel <= covered ? blended : s3_dst;
      result.covered   <= covered;
    end
  end

endmodule

/* rtl/quad_fill_alpha_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_fill_alpha_blend - translucent quad fill over an RGB565 pixel stream
// Blends a status colour into pixels that fall inside a configured quad.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one pixel word (column, row, RGB565) per cycle, valid/stall.
//   out_*  : one result word (pixel, covered flag) per input, valid/stall.
//   cfg_*  : register writes, index 0..6; cfg_ready is always high. Write
//            only while the pipeline is empty.
// Four register stages, in order: edge differences and bounds, cross products,
// crossing parity with channel sums, divide by 255 and select. out_valid rises
// once a word reaches the last stage; throughput is one word per cycle while
// the receiver does not stall.
// When the receiver stalls, stages fill up behind the output register; the
// input stalls only once every stage holds a word, and nothing is lost.
// Synchronous reset empties the pipeline and loads the register defaults:
// vertices 0, enabled, not occupied, alpha 70, image 800 x 600.
// ----------------------------------------------------------------------------
module quad_fill_alpha_blend import qfab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  pix_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pix_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t       cfg;
  pipe_ctrl_t ctrl;
  logic       covered;

  assign cfg_ready = 1'b1;

  qfab_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qfab_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  qfab_inside u_inside (
    .clk     (clk),
    .ctrl    (ctrl),
    .cfg     (cfg),
    .pix     (in_data),
    .covered (covered)
  );

  qfab_blend u_blend (
    .clk       (clk),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .dst_pixel (in_data.dst_pixel),
    .covered   (covered),
    .result    (out_data)
  );

endmodule

/* rtl/qfab_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfab_checker - port-level checks for the quad fill alpha blender
// Watches handshake behaviour at the top level and is bound to it.
// ----------------------------------------------------------------------------
module qfab_checker import qfab_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input pix_in_t     in_data,
  input logic        out_valid,
  input logic        out_stall,
  input pix_out_t    out_data
);

  // input back-pressure only ever comes from a blocked output word
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked output word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word present straight after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("output word changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("input word changed while stalled");

endmodule

bind quad_fill_alpha_blend qfab_checker u_qfab_checker (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for quad_fill_alpha_blend
// Streams pixel words through the shader with random gaps and output stalls.
// A local shading model predicts each result word when its input is taken,
// and the monitor checks every output word against the oldest prediction.
// Register settings change between bursts, once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import qfab_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int MAX_PRINTS = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pix_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pix_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // shadow copy of the register file, updated on each accepted write
  cfg_t     regs;
  pix_in_t  pending[$];
  pix_out_t shaded_q[$];
  logic     quiet = 1'b0;
  int       errors = 0;
  int       n_checked = 0;
  int       n_covered = 0;
  int       n_writes = 0;
  int       n_settings = 0;
  int       n_popped = 0;

  quad_fill_alpha_blend i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint vertex_at(input logic [63:0] packed_v, input int k);
    return longint'(packed_v[LANE_STEP*k +: LANE_W]);
  endfunction

  function automatic logic [63:0] lanes(input int v0, input int v1, input int v2,
                                        input int v3);
    logic [15:0] a0, a1, a2, a3;
    a0 = v0[15:0];
    a1 = v1[15:0];
    a2 = v2[15:0];
    a3 = v3[15:0];
    return {a3, a2, a1, a0};
  endfunction

  function automatic pix_in_t mk_px(input logic [11:0] x, input logic [11:0] y,
                                    input logic [15:0] d);
    pix_in_t p;
    p.pixel_x   = x;
    p.pixel_y   = y;
    p.dst_pixel = d;
    return p;
  endfunction

  function automatic pix_out_t shade_pixel(input pix_in_t p);
    longint      px, py, xa, ya, xb, yb, lhs, rhs;
    logic        hit, flip;
    int          k, j;
    logic [15:0] fill;
    int unsigned a, rc, gc, bc;
    pix_out_t    res;
    px  = longint'(p.pixel_x) << FRAC_BITS;
    py  = longint'(p.pixel_y) << FRAC_BITS;
    hit = 1'b0;
    // even-odd crossing test; edge k runs from the previous vertex j
    for (k = 0; k < NUM_VTX; k++) begin
      j  = (k + NUM_VTX - 1) % NUM_VTX;
      xa = vertex_at(regs.quad_x_coords, k);
      ya = vertex_at(regs.quad_y_coords, k);
      xb = vertex_at(regs.quad_x_coords, j);
      yb = vertex_at(regs.quad_y_coords, j);
      if ((ya > py) != (yb > py)) begin
        lhs  = (px - xa) * (yb - ya);
        rhs  = (xb - xa) * (py - ya);
        flip = (yb > ya) ? (lhs < rhs) : (lhs > rhs);
        if (flip) hit = ~hit;
      end
    end
    res.out_pixel = p.dst_pixel;
    res.covered   = 1'b0;
    if (p.pixel_x < regs.image_width && p.pixel_y < regs.image_height && hit) begin
      fill = !regs.cell_enabled ? FILL_DIS : (regs.cell_occupied ? FILL_OCC : FILL_FREE);
      a  = regs.fill_alpha;
      rc = (fill[15:11] * a + p.dst_pixel[15:11] * (255 - a)) / 255;
      gc = (fill[10:5] * a + p.dst_pixel[10:5] * (255 - a)) / 255;
      bc = (fill[4:0] * a + p.dst_pixel[4:0] * (255 - a)) / 255;
      res.out_pixel = {rc[4:0], gc[5:0], bc[4:0]};
      res.covered   = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // call at a rising edge; returns at a rising edge with the channel idle
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_writes++;
    case (idx)
      REG_QUAD_X:   regs.quad_x_coords = val;
      REG_QUAD_Y:   regs.quad_y_coords = val;
      REG_ENABLED:  regs.cell_enabled  = val[0];
      REG_OCCUPIED: regs.cell_occupied = val[0];
      REG_ALPHA:    regs.fill_alpha    = val[ALPHA_W-1:0];
      REG_WIDTH:    regs.image_width   = val[11:0];
      REG_HEIGHT:   regs.image_height  = val[11:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for every queued word to come back, then let the pipeline settle
  task automatic drain();
    int guard;
    guard = 0;
    while ((pending.size() != 0 || n_checked != n_popped) && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (NUM_STAGES + 2) @(posedge clk);
    n_settings++;
  endtask

  // driver: holds a word until taken, gaps at random unless quiet
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) shaded_q.push_back(shade_pixel(in_data));
      if (pending.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
        in_data  <= pending.pop_front();
        in_valid <= 1'b1;
        n_popped++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : p_monitor
    pix_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (shaded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data));
        end else begin
          want = shaded_q.pop_front();
          n_checked++;
          if (want.covered) n_covered++;
          if (out_data.out_pixel !== want.out_pixel)
            report_mismatch($sformatf("out_pixel %h, expected %h", out_data.out_pixel,
                                      want.out_pixel));
          if (out_data.covered !== want.covered)
            report_mismatch($sformatf("covered %b, expected %b", out_data.covered,
                                      want.covered));
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  initial begin : p_stimulus
    int          ph, k, span, count;
    int          vx[4], vy[4];
    logic [63:0] junk;
    logic [11:0] w, h;
    logic [7:0]  alpha;

    regs.quad_x_coords = '0;
    regs.quad_y_coords = '0;
    regs.cell_enabled  = 1'b1;
    regs.cell_occupied = 1'b0;
    regs.fill_alpha    = 8'd70;
    regs.image_width   = 12'd800;
    regs.image_height  = 12'd600;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: all vertices at the origin, so nothing is covered
    pending.push_back(mk_px(12'd0, 12'd0, 16'h0000));
    pending.push_back(mk_px(12'hFFF, 12'hFFF, 16'hFFFF));
    pending.push_back(mk_px(12'd799, 12'd599, 16'hA5A5));
    drain();

    // axis-aligned rectangle; its horizontal edges never cross a row
    write_reg(REG_QUAD_X, lanes(10*16, 100*16, 100*16, 10*16));
    write_reg(REG_QUAD_Y, lanes(10*16, 10*16, 60*16, 60*16));
    write_reg(REG_ALPHA, 64'd255);
    pending.push_back(mk_px(12'd50, 12'd30, 16'h0000));
    pending.push_back(mk_px(12'd10, 12'd10, 16'hFFFF));
    pending.push_back(mk_px(12'd100, 12'd60, 16'h1234));
    pending.push_back(mk_px(12'd5, 12'd30, 16'h5A5A));
    pending.push_back(mk_px(12'd50, 12'd5, 16'hC3C3));
    pending.push_back(mk_px(12'd99, 12'd59, 16'h5555));
    drain();

    // occupied with zero alpha: pixel unchanged yet still covered
    write_reg(REG_OCCUPIED, 64'd1);
    write_reg(REG_ALPHA, 64'd0);
    pending.push_back(mk_px(12'd50, 12'd30, 16'hFFFF));
    pending.push_back(mk_px(12'd20, 12'd20, 16'h0000));
    drain();

    // disabled cell, half alpha, image bounds cutting through the quad
    write_reg(REG_ENABLED, 64'd0);
    write_reg(REG_ALPHA, 64'd128);
    write_reg(REG_WIDTH, 64'd50);
    write_reg(REG_HEIGHT, 64'd30);
    pending.push_back(mk_px(12'd49, 12'd29, 16'h8410));
    pending.push_back(mk_px(12'd50, 12'd29, 16'hFFFF));
    pending.push_back(mk_px(12'd49, 12'd30, 16'h7BEF));
    drain();

    // collinear vertices
    write_reg(REG_QUAD_X, lanes(0, 1600, 3200, 800));
    write_reg(REG_QUAD_Y, lanes(0, 1600, 3200, 800));
    write_reg(REG_WIDTH, 64'd4095);
    write_reg(REG_HEIGHT, 64'd4095);
    pending.push_back(mk_px(12'd50, 12'd50, 16'h1111));
    pending.push_back(mk_px(12'd51, 12'd50, 16'h2222));
    pending.push_back(mk_px(12'd0, 12'd0, 16'h3333));
    drain();

    // quad out to the top of the vertex range
    write_reg(REG_QUAD_X, lanes(0, 16'hFFFF, 16'hFFFF, 0));
    write_reg(REG_QUAD_Y, lanes(0, 0, 16'hFFFF, 16'hFFFF));
    write_reg(REG_ENABLED, 64'd1);
    write_reg(REG_ALPHA, 64'd200);
    pending.push_back(mk_px(12'hFFF, 12'hFFF, 16'hFFFF));
    pending.push_back(mk_px(12'd0, 12'd0, 16'h0000));
    pending.push_back(mk_px(12'd2048, 12'd1000, 16'hF81F));
    drain();

    // empty image; an unmapped index must leave everything alone
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_HEIGHT, 64'd0);
    write_reg(REG_UNUSED, '1);
    pending.push_back(mk_px(12'd0, 12'd0, 16'h07E0));
    pending.push_back(mk_px(12'd100, 12'd100, 16'h001F));
    drain();

    // one-pixel image
    write_reg(REG_WIDTH, 64'd1);
    write_reg(REG_HEIGHT, 64'd1);
    pending.push_back(mk_px(12'd0, 12'd0, 16'hABCD));
    pending.push_back(mk_px(12'd1, 12'd0, 16'hABCD));
    pending.push_back(mk_px(12'd0, 12'd1, 16'hABCD));
    drain();

    // random settings; most quads are small with pixels drawn around them
    for (ph = 0; ph < 18; ph++) begin
      span = ($urandom_range(3) == 0) ? 4095 : $urandom_range(8, 200);
      for (k = 0; k < 4; k++) begin
        vx[k] = $urandom_range(0, span * 16 + 15);
        vy[k] = $urandom_range(0, span * 16 + 15);
      end
      write_reg(REG_QUAD_X, lanes(vx[0], vx[1], vx[2], vx[3]));
      write_reg(REG_QUAD_Y, lanes(vy[0], vy[1], vy[2], vy[3]));
      // narrow registers get junk in the unused upper bits
      junk = {$urandom, $urandom};
      write_reg(REG_ENABLED, {junk[63:1], ($urandom_range(3) != 0)});
      junk = {$urandom, $urandom};
      write_reg(REG_OCCUPIED, {junk[63:1], 1'($urandom_range(1))});
      case ($urandom_range(9))
        0:       alpha = 8'd0;
        1:       alpha = 8'd255;
        default: alpha = 8'($urandom_range(255));
      endcase
      junk = {$urandom, $urandom};
      write_reg(REG_ALPHA, {junk[63:8], alpha});
      w = ($urandom_range(3) == 0) ? 12'($urandom_range(1, span + 1)) : 12'd4095;
      h = ($urandom_range(3) == 0) ? 12'($urandom_range(1, span + 1)) : 12'd4095;
      junk = {$urandom, $urandom};
      write_reg(REG_WIDTH, {junk[63:12], w});
      junk = {$urandom, $urandom};
      write_reg(REG_HEIGHT, {junk[63:12], h});
      quiet <= (ph == 8);
      count = (ph == 8) ? 100 : 25;
      for (k = 0; k < count; k++)
        pending.push_back(mk_px(12'($urandom_range(0, span)), 12'($urandom_range(0, span)),
                                16'($urandom)));
      drain();
      quiet <= 1'b0;
    end

    if (shaded_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", shaded_q.size()));

    $display("Checked %0d pixel words (%0d covered) across %0d register settings,",
             n_checked, n_covered, n_settings);
    $display("using %0d register writes.", n_writes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : p_watchdog
    #2000000;
    $display("Timeout: stimulus or results stuck");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
